// ----- rtl/core/lcd4_pkg.sv -----
// Shared types, constants and the init command table for the 4-bit LCD sequencer.
// No dependencies; used by every module in rtl/core.
package lcd4_pkg;

   localparam int LINE_CHARS   = 16;
   localparam int COUNT_BITS   = 5;
   localparam int OP_BITS      = 4;
   localparam int STEP_BITS    = 6;
   localparam int MAX_SNAPS    = 43;
   localparam int JOB_DEPTH    = 2;
   localparam int JOB_PTR_BITS = 1;
   localparam int JOB_CNT_BITS = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 21;
   localparam int PULSE_BITS   = 10;
   localparam int SETTLE_BITS  = 17;
   localparam int HOLD_BITS    = 21;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PULSE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SETTLE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAKEUP = 2'd2;

   localparam logic [OP_BITS-1:0] CLEAR_FIRST_OP = 4'd9;
   localparam logic [OP_BITS-1:0] INIT_LAST_OP   = 4'd10;

   localparam logic [7:0] CMD_HOME  = 8'h02;
   localparam logic [7:0] CMD_LINE2 = 8'hC0;

   typedef enum logic [2:0] {
      FUNC_INIT  = 3'd0,
      FUNC_CLEAR = 3'd1,
      FUNC_LINE  = 3'd2,
      FUNC_TEXT  = 3'd3,
      FUNC_RAW   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      JOB_INIT  = 2'd0,
      JOB_CLEAR = 2'd1,
      JOB_WRITE = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   value;
      logic         rs;
      logic         half;
      logic         settle;
   } job_type;

   // One step of a command: a wait, or a nibble/byte write.
   typedef struct packed {
      logic [7:0] value;
      logic       rs;
      logic       half;
      logic       settle;
      logic       wait_op;
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_WAIT      = 3'd1,
      ST_HI_ON     = 3'd2,
      ST_HI_OFF    = 3'd3,
      ST_LO_ON     = 3'd4,
      ST_LO_OFF    = 3'd5,
      ST_PINS_LOW  = 3'd6
   } seq_state_type;

   typedef struct packed {
      logic                 idle;
      logic [STEP_BITS-1:0] step;
   } back_status_type;

   // Init sequence; clear is its tail starting at CLEAR_FIRST_OP.
   function automatic op_type init_op(input logic [OP_BITS-1:0] op);
      op_type o;
      o = '0;
      unique case (op)
         4'd0:                   o.wait_op = 1'b1;
         4'd1, 4'd2, 4'd3: begin
            o.value = 8'h03; o.half = 1'b1; o.settle = 1'b1;
         end
         4'd4: begin
            o.value = 8'h02; o.half = 1'b1;
         end
         4'd5:                   o.value = 8'h28;
         4'd6:                   o.value = 8'h08;
         4'd7:                   o.value = 8'h0C;
         4'd8:                   o.value = 8'h06;
         4'd9:                   o.value = 8'h01;
         4'd10: begin
            o.value = 8'h00; o.settle = 1'b1;
         end
         default:                o = '0;
      endcase
      return o;
   endfunction

   function automatic op_type job_op(input job_type j, input logic [OP_BITS-1:0] op);
      op_type o;
      if (j.kind == JOB_WRITE) begin
         o.value   = j.value;
         o.rs      = j.rs;
         o.half    = j.half;
         o.settle  = j.settle;
         o.wait_op = 1'b0;
      end else begin
         o = init_op(op);
      end
      return o;
   endfunction

   function automatic seq_state_type first_state(input op_type o);
      if (o.wait_op) return ST_WAIT;
      else if (o.half) return ST_LO_ON;
      else return ST_HI_ON;
   endfunction

endpackage

// ----- rtl/core/lcd4_front.sv -----
// Front end: accepts command requests, drops the ones that emit nothing,
// tracks the per-line character count and builds jobs. Uses lcd4_pkg.
module lcd4_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [2:0]        req_func,
   input  logic [7:0]        req_byte_value,
   input  logic              req_line_select,
   input  logic              req_register_select,
   input  logic              req_nibble_only,
   input  logic              q_full,
   output logic              req_full,
   output logic              q_push,
   output lcd4_pkg::job_type q_job
);

   logic [lcd4_pkg::COUNT_BITS-1:0] line_count_ff, line_count_in;
   logic accept, keep;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept && keep;

   always_comb begin
      keep          = 1'b1;
      line_count_in = line_count_ff;
      q_job         = '0;
      q_job.kind    = lcd4_pkg::JOB_WRITE;
      unique case (lcd4_pkg::func_type'(req_func))
         lcd4_pkg::FUNC_INIT: begin
            q_job.kind    = lcd4_pkg::JOB_INIT;
            line_count_in = '0;
         end
         lcd4_pkg::FUNC_CLEAR: begin
            q_job.kind    = lcd4_pkg::JOB_CLEAR;
            line_count_in = '0;
         end
         lcd4_pkg::FUNC_LINE: begin
            q_job.value   = req_line_select ? lcd4_pkg::CMD_LINE2 : lcd4_pkg::CMD_HOME;
            q_job.settle  = 1'b1;
            line_count_in = '0;
         end
         lcd4_pkg::FUNC_TEXT: begin
            q_job.value = req_byte_value;
            q_job.rs    = 1'b1;
            if (req_byte_value == 8'd0 ||
                  line_count_ff >= lcd4_pkg::COUNT_BITS'(lcd4_pkg::LINE_CHARS)) begin
               keep = 1'b0;
            end else begin
               line_count_in = line_count_ff + 1'b1;
            end
         end
         lcd4_pkg::FUNC_RAW: begin
            q_job.value = req_byte_value;
            q_job.rs    = req_register_select;
            q_job.half  = req_nibble_only;
         end
         default: keep = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
      end else if (accept) begin
         line_count_ff <= line_count_in;
      end
   end

endmodule

// ----- rtl/core/lcd4_job_fifo.sv -----
// Short job queue between the front end and the sequencer.
// Uses lcd4_pkg for the job type and depth.
module lcd4_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcd4_pkg::job_type push_job,
   input  logic              pop,
   output lcd4_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);

   lcd4_pkg::job_type jobs_ff [lcd4_pkg::JOB_DEPTH];
   logic [lcd4_pkg::JOB_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [lcd4_pkg::JOB_CNT_BITS-1:0] count_ff;
   logic do_push, do_pop;

   assign full     = count_ff == lcd4_pkg::JOB_CNT_BITS'(lcd4_pkg::JOB_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = jobs_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         jobs_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ----- rtl/core/lcd4_back.sv -----
// Back end: walks each job step by step and emits one pin snapshot per cycle,
// while the receiver keeps popping, into a one-entry output register. Uses lcd4_pkg.
module lcd4_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  lcd4_pkg::job_type                 q_job,
   output logic                              q_pop,
   input  logic [lcd4_pkg::PULSE_BITS-1:0]   pulse_us,
   input  logic [lcd4_pkg::SETTLE_BITS-1:0]  settle_us,
   input  logic [lcd4_pkg::HOLD_BITS-1:0]    wakeup_us,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic                              rsp_rs_pin,
   output logic                              rsp_enable_pin,
   output logic [3:0]                        rsp_data_nibble,
   output logic [lcd4_pkg::HOLD_BITS-1:0]    rsp_hold_us,
   output logic                              rsp_last,
   output lcd4_pkg::back_status_type         status
);

   lcd4_pkg::seq_state_type state_ff, state_in;
   lcd4_pkg::job_type job_ff, job_in;
   logic [lcd4_pkg::OP_BITS-1:0]   op_ff, op_in, next_op, head_first_op;
   logic [lcd4_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic out_valid_ff, out_valid_in;
   logic advance, emit, last_op;
   lcd4_pkg::op_type cur_op;

   logic                            snap_rs, snap_en, snap_last;
   logic [3:0]                      snap_nib;
   logic [lcd4_pkg::HOLD_BITS-1:0]  snap_hold;

   assign advance       = !out_valid_ff || rsp_pop;
   assign cur_op        = lcd4_pkg::job_op(job_ff, op_ff);
   assign next_op       = op_ff + 1'b1;
   assign last_op       = job_ff.kind == lcd4_pkg::JOB_WRITE || op_ff == lcd4_pkg::INIT_LAST_OP;
   assign head_first_op = (q_job.kind == lcd4_pkg::JOB_CLEAR) ? lcd4_pkg::CLEAR_FIRST_OP : '0;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      op_in     = op_ff;
      step_in   = step_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      snap_rs   = 1'b0;
      snap_en   = 1'b0;
      snap_nib  = 4'd0;
      snap_hold = lcd4_pkg::HOLD_BITS'(pulse_us);
      snap_last = 1'b0;
      unique case (state_ff)
         lcd4_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               op_in    = head_first_op;
               step_in  = '0;
               state_in = lcd4_pkg::first_state(lcd4_pkg::job_op(q_job, head_first_op));
            end
         end
         lcd4_pkg::ST_WAIT: begin
            snap_hold = wakeup_us;
            if (advance) begin
               op_in    = next_op;
               state_in = lcd4_pkg::first_state(lcd4_pkg::job_op(job_ff, next_op));
            end
         end
         lcd4_pkg::ST_HI_ON: begin
            snap_rs  = cur_op.rs;
            snap_en  = 1'b1;
            snap_nib = cur_op.value[7:4];
            if (advance) state_in = lcd4_pkg::ST_HI_OFF;
         end
         lcd4_pkg::ST_HI_OFF: begin
            snap_rs  = cur_op.rs;
            snap_nib = cur_op.value[7:4];
            if (advance) state_in = lcd4_pkg::ST_LO_ON;
         end
         lcd4_pkg::ST_LO_ON: begin
            snap_rs  = cur_op.rs;
            snap_en  = 1'b1;
            snap_nib = cur_op.value[3:0];
            if (advance) state_in = lcd4_pkg::ST_LO_OFF;
         end
         lcd4_pkg::ST_LO_OFF: begin
            snap_rs  = cur_op.rs;
            snap_nib = cur_op.value[3:0];
            if (advance) state_in = lcd4_pkg::ST_PINS_LOW;
         end
         lcd4_pkg::ST_PINS_LOW: begin
            snap_hold = cur_op.settle ? lcd4_pkg::HOLD_BITS'(settle_us) : '0;
            snap_last = last_op;
            if (advance) begin
               if (last_op) begin
                  state_in = lcd4_pkg::ST_IDLE;
               end else begin
                  op_in    = next_op;
                  state_in = lcd4_pkg::first_state(lcd4_pkg::job_op(job_ff, next_op));
               end
            end
         end
         default: state_in = lcd4_pkg::ST_IDLE;
      endcase
      if (state_ff != lcd4_pkg::ST_IDLE && advance) begin
         emit    = 1'b1;
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) out_valid_in = 1'b1;
      else if (rsp_pop) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcd4_pkg::ST_IDLE;
         op_ff        <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         rsp_rs_pin      <= snap_rs;
         rsp_enable_pin  <= snap_en;
         rsp_data_nibble <= snap_nib;
         rsp_hold_us     <= snap_hold;
         rsp_last        <= snap_last;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign status.idle = state_ff == lcd4_pkg::ST_IDLE;
   assign status.step = step_ff;

endmodule

// ----- rtl/core/char_lcd_4bit_interface_sequencer_core.sv -----
// Top level of the 4-bit character LCD sequencer.
// Depends on lcd4_pkg, lcd4_front, lcd4_job_fifo and lcd4_back.
//
// Usage:
//   Request channel (req_*): push a command while req_full is low. func selects
//   init, clear, line select, text character or raw write. Text past the line
//   length, zero characters and unused func codes are taken and dropped.
//   Response channel (rsp_*): each response is one pin snapshot (rs, enable,
//   nibble, hold time); rsp_last marks the final snapshot of a command.
//   Pop while rsp_empty is low.
//   CSR channel (csr_*): always ready; index 0 pulse_us, 1 settle_us,
//   2 wakeup_us. Write only while the block is idle.
// Timing:
//   The first snapshot of a command passes through the job queue and the
//   sequencer state before it shows. The sequencer then emits one snapshot
//   per cycle while the receiver pops, and idles between commands. The sequencer's
//   single output register sets this pace. Two commands can wait in the job
//   queue, so requests keep flowing while the sequencer works.
//   When the receiver stalls, the output register holds and the sequencer
//   stops; the queue fills, then req_full rises.
// Reset: clears the queue, the line count and the sequencer, and loads the
//   register defaults (100, 5000, 1000000).
module char_lcd_4bit_interface_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [2:0]                          req_func,
   input  logic [7:0]                          req_byte_value,
   input  logic                                req_line_select,
   input  logic                                req_register_select,
   input  logic                                req_nibble_only,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_rs_pin,
   output logic                                rsp_enable_pin,
   output logic [3:0]                          rsp_data_nibble,
   output logic [lcd4_pkg::HOLD_BITS-1:0]      rsp_hold_us,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcd4_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [lcd4_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic [lcd4_pkg::PULSE_BITS-1:0]  pulse_us_ff;
   logic [lcd4_pkg::SETTLE_BITS-1:0] settle_us_ff;
   logic [lcd4_pkg::HOLD_BITS-1:0]   wakeup_us_ff;

   logic                      q_push, q_pop, q_full, q_empty;
   lcd4_pkg::job_type         push_job, head_job;
   lcd4_pkg::back_status_type back_status;

   // Config registers: no back-pressure, index beyond the list is ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_us_ff  <= lcd4_pkg::PULSE_BITS'(100);
         settle_us_ff <= lcd4_pkg::SETTLE_BITS'(5000);
         wakeup_us_ff <= lcd4_pkg::HOLD_BITS'(1000000);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lcd4_pkg::CSR_PULSE:  pulse_us_ff  <= csr_data[lcd4_pkg::PULSE_BITS-1:0];
            lcd4_pkg::CSR_SETTLE: settle_us_ff <= csr_data[lcd4_pkg::SETTLE_BITS-1:0];
            lcd4_pkg::CSR_WAKEUP: wakeup_us_ff <= csr_data[lcd4_pkg::HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Classify requests and drop the ones that emit nothing.
   lcd4_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_func            (req_func),
      .req_byte_value      (req_byte_value),
      .req_line_select     (req_line_select),
      .req_register_select (req_register_select),
      .req_nibble_only     (req_nibble_only),
      .q_full              (q_full),
      .req_full            (req_full),
      .q_push              (q_push),
      .q_job               (push_job)
   );

   // Decouple the front end from the sequencer.
   lcd4_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Expand jobs into pin snapshots.
   lcd4_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_job           (head_job),
      .q_pop           (q_pop),
      .pulse_us        (pulse_us_ff),
      .settle_us       (settle_us_ff),
      .wakeup_us       (wakeup_us_ff),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_rs_pin      (rsp_rs_pin),
      .rsp_enable_pin  (rsp_enable_pin),
      .rsp_data_nibble (rsp_data_nibble),
      .rsp_hold_us     (rsp_hold_us),
      .rsp_last        (rsp_last),
      .status          (back_status)
   );

   // A command never emits more than the init sequence's snapshots. The count
   // restarts when the next job is taken, even while the previous command's
   // last snapshot still waits in the output register.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (back_status.step <= lcd4_pkg::STEP_BITS'(lcd4_pkg::MAX_SNAPS)))
      else $error("snapshot count out of range");

   // The final snapshot of a command is always the pins-low one.
   a_last_pins_low: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |-> (!rsp_rs_pin && !rsp_enable_pin &&
                                    rsp_data_nibble == 4'd0))
      else $error("last snapshot does not have all pins low");

   // An idle sequencer emits nothing, so a popped snapshot leaves the output empty.
   a_idle_drains: assert property (@(posedge clock) disable iff (reset)
      (back_status.idle && !rsp_empty && rsp_pop) |=> rsp_empty)
      else $error("snapshot appeared while sequencer idle");

endmodule

// ----- sim/char_lcd_4bit_interface_sequencer_core_tb.sv -----
// Self-checking testbench for the 4-bit character LCD sequencer core.
// Depends on lcd4_pkg and char_lcd_4bit_interface_sequencer_core; needs no other files.
`timescale 1ns / 1ps

module char_lcd_4bit_interface_sequencer_core_tb;

   // Func codes past the last defined operation; the block takes and drops them.
   localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] FUNC_LAST_CODE    = 3'd7;

   // Bytes of the init and clear sequences.
   localparam logic [7:0] WAKE_NIBBLE     = 8'h03;
   localparam logic [7:0] SET_4BIT        = 8'h02;
   localparam logic [7:0] MODE_4BIT_2LINE = 8'h28;
   localparam logic [7:0] DISPLAY_OFF     = 8'h08;
   localparam logic [7:0] DISPLAY_ON      = 8'h0C;
   localparam logic [7:0] ENTRY_INCREMENT = 8'h06;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CLEAR_PAD       = 8'h00;

   // Cycles to let pass after the last snapshot: covers the request-to-snapshot
   // delay, the rest between commands and dropped requests in flight.
   localparam int DRAIN_SLACK = 50;

   // One pin snapshot as the result ports show it.
   typedef struct packed {
      logic                           rs;
      logic                           enable;
      logic [3:0]                     nibble;
      logic [lcd4_pkg::HOLD_BITS-1:0] hold;
      logic                           last;
   } pin_snapshot_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_push = 1'b0;
   logic                               req_full;
   logic [2:0]                         req_func = '0;
   logic [7:0]                         req_byte_value = '0;
   logic                               req_line_select = 1'b0;
   logic                               req_register_select = 1'b0;
   logic                               req_nibble_only = 1'b0;
   logic                               rsp_empty;
   logic                               rsp_pop = 1'b0;
   logic                               rsp_rs_pin;
   logic                               rsp_enable_pin;
   logic [3:0]                         rsp_data_nibble;
   logic [lcd4_pkg::HOLD_BITS-1:0]     rsp_hold_us;
   logic                               rsp_last;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [lcd4_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [lcd4_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   // Predictor state: the block's registers and its per-line character count.
   logic [lcd4_pkg::PULSE_BITS-1:0]    enable_hold = 10'd100;
   logic [lcd4_pkg::SETTLE_BITS-1:0]   settle_hold = 17'd5000;
   logic [lcd4_pkg::HOLD_BITS-1:0]     wakeup_hold = 21'd1000000;
   logic [lcd4_pkg::COUNT_BITS-1:0]    line_chars  = '0;

   pin_snapshot_type         cmd_pins[$];     // snapshots of the request in hand
   pin_snapshot_type         lcd_pins_q[$];   // snapshots still owed by the block

   int                       failures        = 0;
   int                       send_idle_pct   = 0;
   int                       pop_stall_pct   = 0;
   int                       hold_off_cycles = 0;

   char_lcd_4bit_interface_sequencer_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_func            (req_func),
      .req_byte_value      (req_byte_value),
      .req_line_select     (req_line_select),
      .req_register_select (req_register_select),
      .req_nibble_only     (req_nibble_only),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_rs_pin          (rsp_rs_pin),
      .rsp_enable_pin      (rsp_enable_pin),
      .rsp_data_nibble     (rsp_data_nibble),
      .rsp_hold_us         (rsp_hold_us),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #1 clock = ~clock;

   // Hard stop in case the block hangs or loses snapshots.
   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   task automatic add_pins(input logic rs, input logic enable, input logic [3:0] nibble,
                           input logic [lcd4_pkg::HOLD_BITS-1:0] hold);
      pin_snapshot_type s;
      s.rs     = rs;
      s.enable = enable;
      s.nibble = nibble;
      s.hold   = hold;
      s.last   = 1'b0;
      cmd_pins.push_back(s);
   endtask

   // One LCD write: high nibble unless low_only, low nibble, then pins low.
   // Each nibble is an enable-high snapshot followed by an enable-low one.
   task automatic write_lcd_byte(input logic [7:0] value, input logic rs, input logic low_only,
                                 input logic [lcd4_pkg::HOLD_BITS-1:0] after_hold);
      if (!low_only) begin
         add_pins(rs, 1'b1, value[7:4], lcd4_pkg::HOLD_BITS'(enable_hold));
         add_pins(rs, 1'b0, value[7:4], lcd4_pkg::HOLD_BITS'(enable_hold));
      end
      add_pins(rs, 1'b1, value[3:0], lcd4_pkg::HOLD_BITS'(enable_hold));
      add_pins(rs, 1'b0, value[3:0], lcd4_pkg::HOLD_BITS'(enable_hold));
      add_pins(1'b0, 1'b0, 4'h0, after_hold);
   endtask

   task automatic clear_display();
      write_lcd_byte(CMD_CLEAR, 1'b0, 1'b0, '0);
      write_lcd_byte(CLEAR_PAD, 1'b0, 1'b0, lcd4_pkg::HOLD_BITS'(settle_hold));
      line_chars = '0;
   endtask

   // Work out the snapshots that one accepted request owes, and queue them.
   task automatic predict_lcd_pins(input logic [2:0] func, input logic [7:0] value,
                                   input logic line, input logic rsel, input logic half);
      pin_snapshot_type s;
      cmd_pins.delete();
      case (func)
         lcd4_pkg::FUNC_INIT: begin
            add_pins(1'b0, 1'b0, 4'h0, wakeup_hold);
            repeat (3) begin
               write_lcd_byte(WAKE_NIBBLE, 1'b0, 1'b1, lcd4_pkg::HOLD_BITS'(settle_hold));
            end
            write_lcd_byte(SET_4BIT, 1'b0, 1'b1, '0);
            write_lcd_byte(MODE_4BIT_2LINE, 1'b0, 1'b0, '0);
            write_lcd_byte(DISPLAY_OFF, 1'b0, 1'b0, '0);
            write_lcd_byte(DISPLAY_ON, 1'b0, 1'b0, '0);
            write_lcd_byte(ENTRY_INCREMENT, 1'b0, 1'b0, '0);
            clear_display();
         end
         lcd4_pkg::FUNC_CLEAR: clear_display();
         lcd4_pkg::FUNC_LINE: begin
            write_lcd_byte(line ? lcd4_pkg::CMD_LINE2 : lcd4_pkg::CMD_HOME, 1'b0, 1'b0,
                           lcd4_pkg::HOLD_BITS'(settle_hold));
            line_chars = '0;
         end
         lcd4_pkg::FUNC_TEXT: begin
            // Drop the zero character and anything past the end of the line.
            if (value != 8'h00 && line_chars < lcd4_pkg::LINE_CHARS) begin
               write_lcd_byte(value, 1'b1, 1'b0, '0);
               line_chars = line_chars + 1'b1;
            end
         end
         lcd4_pkg::FUNC_RAW: write_lcd_byte(value, rsel, half, '0);
         default: ;
      endcase
      if (cmd_pins.size() != 0) begin
         s = cmd_pins[cmd_pins.size() - 1];
         s.last = 1'b1;
         cmd_pins[cmd_pins.size() - 1] = s;
      end
      foreach (cmd_pins[i]) lcd_pins_q.push_back(cmd_pins[i]);
   endtask

   // ---------------------------------------------------------------------
   // Result side: pop at random, hold off on request, check every snapshot
   // ---------------------------------------------------------------------

   // Decide pop at the falling edge; a pending hold-off wins over the random stall.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_pop <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Compare each popped snapshot with the oldest one owed.
   always @(posedge clock) begin
      pin_snapshot_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (lcd_pins_q.size() == 0) begin
            $error("unexpected snapshot: rs=%0d en=%0d nibble=%0d hold=%0d last=%0d",
                   rsp_rs_pin, rsp_enable_pin, rsp_data_nibble, rsp_hold_us, rsp_last);
            failures++;
         end else begin
            want = lcd_pins_q.pop_front();
            if (rsp_rs_pin !== want.rs) begin
               $error("rs_pin: expected %0d, got %0d", want.rs, rsp_rs_pin);
               failures++;
            end
            if (rsp_enable_pin !== want.enable) begin
               $error("enable_pin: expected %0d, got %0d", want.enable, rsp_enable_pin);
               failures++;
            end
            if (rsp_data_nibble !== want.nibble) begin
               $error("data_nibble: expected %0d, got %0d", want.nibble, rsp_data_nibble);
               failures++;
            end
            if (rsp_hold_us !== want.hold) begin
               $error("hold_us: expected %0d, got %0d", want.hold, rsp_hold_us);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one request; entered and left at a falling edge. Push stays high on
   // return so back-to-back requests need no drop and re-raise.
   task automatic push_command(input logic [2:0] func, input logic [7:0] value,
                               input logic line, input logic rsel, input logic half);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push            <= 1'b1;
      req_func            <= func;
      req_byte_value      <= value;
      req_line_select     <= line;
      req_register_select <= rsel;
      req_nibble_only     <= half;
      do @(posedge clock); while (req_full);
      predict_lcd_pins(func, value, line, rsel, half);
      @(negedge clock);
   endtask

   // Half text, so lines fill up and run over; the rest covers every other code.
   task automatic push_random_command();
      int         pick;
      logic [2:0] func;
      logic [7:0] value;
      pick  = $urandom_range(99);
      value = 8'($urandom_range(255));
      if (pick < 50) begin
         func = lcd4_pkg::FUNC_TEXT;
         if ($urandom_range(19) == 0) value = 8'h00;
      end else if (pick < 70) func = lcd4_pkg::FUNC_RAW;
      else if (pick < 81) func = lcd4_pkg::FUNC_LINE;
      else if (pick < 89) func = lcd4_pkg::FUNC_CLEAR;
      else if (pick < 94) func = lcd4_pkg::FUNC_INIT;
      else func = 3'($urandom_range(FUNC_LAST_CODE, FUNC_FIRST_UNUSED));
      push_command(func, value, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
   endtask

   // Drop push, wait for every owed snapshot, then let the pipeline go quiet.
   task automatic wait_until_drained();
      req_push <= 1'b0;
      @(negedge clock);
      while (lcd_pins_q.size() != 0) @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   // Write one register; only call with the block drained.
   task automatic write_register(input logic [lcd4_pkg::CSR_IDX_BITS-1:0] index,
                                 input logic [lcd4_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         lcd4_pkg::CSR_PULSE:  enable_hold = data[lcd4_pkg::PULSE_BITS-1:0];
         lcd4_pkg::CSR_SETTLE: settle_hold = data[lcd4_pkg::SETTLE_BITS-1:0];
         lcd4_pkg::CSR_WAKEUP: wakeup_hold = data[lcd4_pkg::HOLD_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_timing(input int pulse, input int settle, input int wakeup);
      wait_until_drained();
      write_register(lcd4_pkg::CSR_PULSE, lcd4_pkg::CSR_DATA_BITS'(pulse));
      write_register(lcd4_pkg::CSR_SETTLE, lcd4_pkg::CSR_DATA_BITS'(settle));
      write_register(lcd4_pkg::CSR_WAKEUP, lcd4_pkg::CSR_DATA_BITS'(wakeup));
   endtask

   task automatic run_random_phase(input int count, input int send_idle, input int pop_stall);
      send_idle_pct = send_idle;
      pop_stall_pct = pop_stall;
      repeat (count) push_random_command();
      wait_until_drained();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every defined func code and the first unused one, with the reset register defaults.
   task automatic test_each_function();
      push_command(lcd4_pkg::FUNC_INIT, 8'h00, 1'b0, 1'b0, 1'b0);
      push_command(lcd4_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
      push_command(lcd4_pkg::FUNC_LINE, 8'h00, 1'b0, 1'b0, 1'b0);
      push_command(lcd4_pkg::FUNC_LINE, 8'hFF, 1'b1, 1'b1, 1'b1);
      push_command(lcd4_pkg::FUNC_RAW, 8'hFF, 1'b1, 1'b0, 1'b0);
      push_command(lcd4_pkg::FUNC_RAW, 8'hA5, 1'b0, 1'b1, 1'b1);
      push_command(lcd4_pkg::FUNC_TEXT, 8'h00, 1'b0, 1'b0, 1'b0);
      push_command(FUNC_FIRST_UNUSED, 8'h5A, 1'b1, 1'b1, 1'b1);
      wait_until_drained();
   endtask

   // Fill one line: the character past the line length must produce nothing.
   task automatic test_line_overflow();
      push_command(lcd4_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i <= lcd4_pkg::LINE_CHARS; i++) begin
         push_command(lcd4_pkg::FUNC_TEXT,
                      8'((i == 0) ? 8'hFF : (i == 1) ? 8'h01 : 8'h40 + i),
                      1'b0, 1'b0, 1'b0);
      end
      wait_until_drained();
   endtask

   // Hold off the receiver long enough for the queue to fill and req_full to
   // rise, then pause the sender until everything owed has come out.
   task automatic test_backpressure();
      send_idle_pct   = 0;
      pop_stall_pct   = 0;
      hold_off_cycles = 400;
      repeat (14) push_random_command();
      wait_until_drained();
      repeat (6) push_random_command();
      wait_until_drained();
   endtask

   task automatic test_random_no_idle();
      set_timing(1, 0, 0);
      run_random_phase(70, 0, 0);
   endtask

   task automatic test_random_sender_idle();
      set_timing(1000, 100000, 2000000);
      run_random_phase(70, 79, 0);
   endtask

   task automatic test_random_receiver_stall();
      // All-ones fields, beyond the documented ranges.
      set_timing(1023, 131071, 2097151);
      run_random_phase(70, 0, 79);
   endtask

   task automatic test_random_both_idle();
      // Zero pulse gives zero-length enable holds.
      set_timing(0, $urandom_range(131071), $urandom_range(2097151));
      run_random_phase(40, 31, 31);
      set_timing($urandom_range(1000, 1), $urandom_range(100000), $urandom_range(2000000));
      run_random_phase(40, 31, 31);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_each_function();
      test_line_overflow();
      test_backpressure();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      wait_until_drained();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
